// File: hdl/assert_macros.svh
// assertion helpers shared by the timer bank modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: hdl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Types and constants shared by the periodic timer bank modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

  // operation codes
  localparam logic [1:0] FUNC_CREATE  = 2'd0;
  localparam logic [1:0] FUNC_SUSPEND = 2'd1;
  localparam logic [1:0] FUNC_RESUME  = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam int COUNT_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int HANDLE_W = 3;
  localparam int MASK_W   = 8;

  // remainder unit iterates once per dividend bit
  localparam int DIV_STEPS = COUNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic                create_failed;
    logic [MASK_W-1:0]   fire_mask;
  } rsp_t;

  // request to the remainder unit
  typedef struct packed {
    logic                start;
    logic [COUNT_W-1:0]  dividend;
    logic [PERIOD_W-1:0] divisor;
  } mod_req_t;

  // status from the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_stat_t;

endpackage

// File: hdl/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ptb_mod.sv
// ----------------------------------------------------------------------------
// ptb_mod
// Bit-serial 32-by-16 restoring remainder unit; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptb_mod
  import ptb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mod_req_t  req,
  output mod_stat_t stat
);

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COUNT_W-1:0]   dq;
  logic [PERIOD_W-1:0]  dvs;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W:0]    shifted;
  logic                 fits;

  // one dividend bit shifted into the partial remainder per cycle
  assign shifted = {rem, dq[COUNT_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (run) begin
      dq <= dq << 1;
      if (fits) begin
        rem <= PERIOD_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[PERIOD_W-1:0];
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

  `ASSERT_PROP(a_start_idle, clk, rst, req.start |-> !run, "remainder unit started while busy")
  `ASSERT_PROP(a_done_pulse, clk, rst, done |=> !done, "remainder done held over two cycles")

endmodule

// File: hdl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timer slots with create, suspend, resume and tick.
// ----------------------------------------------------------------------------
// One item at a time. Create, suspend and resume pass from idle through the
// finish state. A tick scans each created slot in turn: a slot that is
// paused or has a zero period is skipped, any other runs the bit-serial
// 32-by-16 remainder unit, one bit per cycle, shared by all slots. Periods
// live in a RAM read one slot at a time; no clearing pass is needed after
// reset. A finished result waits in the output register while the next
// item is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int TIMER_SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state;
  logic [CW-1:0]          used;
  logic [CW-1:0]          idx;
  logic [COUNT_W-1:0]     tick_count;
  logic [TIMER_SLOTS-1:0] paused;
  rsp_t                   res;

  logic                accept;
  logic                full;
  logic                out_free;
  logic                hnd_ok;
  logic [AW-1:0]       hsel;
  logic                ram_we;
  logic [PERIOD_W-1:0] ram_rdata;
  logic                slot_live;
  logic                mask_ok;
  mod_req_t            mreq;
  mod_stat_t           mstat;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (used == CW'(TIMER_SLOTS));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign hnd_ok    = 32'(req.handle) < TIMER_SLOTS;
  assign hsel      = AW'(req.handle);
  assign ram_we    = accept && (req.func == FUNC_CREATE) && !full;
  assign slot_live = (ram_rdata != '0) && !paused[idx[AW-1:0]];
  assign mask_ok   = 32'(idx) < MASK_W;

  // period table; writes happen only on create in idle and read data is used
  // only during a tick scan, so a write never overlaps a read that is used
  ptb_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (TIMER_SLOTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used[AW-1:0]),
    .wdata (req.period),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // shared remainder unit
  assign mreq.start    = (state == ST_WAIT) && slot_live;
  assign mreq.dividend = tick_count;
  assign mreq.divisor  = ram_rdata;

  ptb_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .stat (mstat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      idx        <= '0;
      tick_count <= '0;
      paused     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.func)
              FUNC_CREATE: begin
                if (!full) begin
                  paused[used[AW-1:0]] <= 1'b0;
                  used                 <= used + CW'(1);
                end
                state <= ST_FIN;
              end
              FUNC_SUSPEND: begin
                if (hnd_ok) begin
                  paused[hsel] <= 1'b1;
                end
                state <= ST_FIN;
              end
              FUNC_RESUME: begin
                if (hnd_ok) begin
                  paused[hsel] <= 1'b0;
                end
                state <= ST_FIN;
              end
              FUNC_TICK: begin
                tick_count <= tick_count + COUNT_W'(1);
                idx        <= '0;
                state      <= ST_SCAN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_SCAN: begin
          if (idx == used) begin
            state <= ST_FIN;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (slot_live) begin
            state <= ST_DIV;
          end else begin
            idx   <= idx + CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_DIV: begin
          if (mstat.done) begin
            idx   <= idx + CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result being built
  always_ff @(posedge clk) begin
    if (accept) begin
      res.fire_mask     <= '0;
      res.create_failed <= (req.func == FUNC_CREATE) && full;
      res.new_handle    <= ((req.func == FUNC_CREATE) && !full) ? HANDLE_W'(used) : '0;
    end else if ((state == ST_DIV) && mstat.done && mstat.rem_zero && mask_ok) begin
      res.fire_mask[HANDLE_W'(idx)] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      rsp <= res;
    end
  end

  `ASSERT_NEVER(a_used_bound, clk, rst, used > CW'(TIMER_SLOTS), "slot count beyond bank size")
  `ASSERT_PROP(a_rsp_from_fin, clk, rst, $rose(rsp_valid) |-> $past(state) == ST_FIN, "response without finish")
  `ASSERT_PROP(a_fire_only, clk, rst, rsp_valid && rsp.fire_mask != '0 |-> !rsp.create_failed && rsp.new_handle == '0, "mixed response")

endmodule

// File: sim/periodic_timer_bank_test.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank_test
// Self-checking bench for the periodic timer bank. Requests are driven with
// random gaps on both channels and every transfer is checked against a
// behavioral copy of the slot table, the pause marks and the tick count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_bank_test;
  import ptb_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_GAP     = 9;
  // longest tick runs the remainder unit for all eight slots
  localparam int TICK_CYCLES = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_REQS = 420;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // behavioral copy of the bank
  logic [COUNT_W-1:0]  tick_total;
  logic [PERIOD_W-1:0] slot_period [NUM_SLOTS];
  logic                slot_paused [NUM_SLOTS];
  int                  slots_made;

  rsp_t timer_results_due[$];
  rsp_t oldest_due;
  int   mismatch_count;
  int   quiet_cycles;

  // idle control for the request and result sides
  bit req_idle_on;
  bit rsp_idle_on;
  int rsp_hold_len;

  periodic_timer_bank #(
    .TIMER_SLOTS(NUM_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(bit enabled);
    return enabled ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic req_t make_req(logic [1:0] func, int handle, int period);
    req_t r;
    r.func   = func;
    r.handle = HANDLE_W'(handle);
    r.period = PERIOD_W'(period);
    return r;
  endfunction

  // apply one request to the bank copy and return the result it should give
  function automatic rsp_t step_timer_model(req_t r);
    rsp_t o;
    logic [COUNT_W-1:0] per;
    o = '0;
    case (r.func)
      FUNC_CREATE: begin
        if (slots_made < NUM_SLOTS) begin
          slot_period[slots_made] = r.period;
          slot_paused[slots_made] = 1'b0;
          o.new_handle = HANDLE_W'(slots_made);
          slots_made++;
        end else begin
          o.create_failed = 1'b1;
        end
      end
      FUNC_SUSPEND: slot_paused[r.handle] = 1'b1;
      FUNC_RESUME:  slot_paused[r.handle] = 1'b0;
      default: begin
        tick_total = tick_total + 1;
        for (int i = 0; i < slots_made; i++) begin
          per = COUNT_W'(slot_period[i]);
          if (per != 0 && !slot_paused[i] && (tick_total % per) == 0)
            o.fire_mask[i] = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // offer one request and log its expected result on transfer
  task automatic send_req(req_t item);
    int gap;
    gap = pick_gap(req_idle_on);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    timer_results_due.push_back(step_timer_model(item));
  endtask

  // drop valid right after the last transfer of a burst
  task automatic end_burst();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mark handling on slots not created yet, tick on an empty bank
  task automatic test_unused_slot_marks();
    send_req(make_req(FUNC_SUSPEND, 7, 16'hFFFF));
    send_req(make_req(FUNC_RESUME, 6, 16'h0000));
    send_req(make_req(FUNC_SUSPEND, 3, 16'h1234));
    send_req(make_req(FUNC_TICK, 0, 0));
    end_burst();
  endtask

  // fill every slot, zero period and widest period included
  task automatic test_create_fill();
    send_req(make_req(FUNC_CREATE, 0, 1));
    send_req(make_req(FUNC_CREATE, 7, 0));
    send_req(make_req(FUNC_CREATE, 0, 16'hFFFF));
    send_req(make_req(FUNC_CREATE, 5, 2));
    send_req(make_req(FUNC_CREATE, 0, 3));
    send_req(make_req(FUNC_CREATE, 2, 4));
    send_req(make_req(FUNC_CREATE, 0, 6));
    send_req(make_req(FUNC_CREATE, 0, 5));
    // slot 3 was suspended before create, so it must fire here
    send_req(make_req(FUNC_TICK, 7, 16'hFFFF));
    send_req(make_req(FUNC_TICK, 0, 0));
    end_burst();
  endtask

  // create once the table is full
  task automatic test_table_full();
    send_req(make_req(FUNC_CREATE, 0, 7));
    send_req(make_req(FUNC_CREATE, 7, 16'hFFFF));
    end_burst();
  endtask

  // suspend and resume of created slots
  task automatic test_pause_resume();
    send_req(make_req(FUNC_SUSPEND, 0, 0));
    send_req(make_req(FUNC_SUSPEND, 7, 0));
    send_req(make_req(FUNC_TICK, 0, 0));
    send_req(make_req(FUNC_RESUME, 0, 0));
    send_req(make_req(FUNC_TICK, 0, 0));
    send_req(make_req(FUNC_RESUME, 7, 0));
    send_req(make_req(FUNC_TICK, 0, 0));
    end_burst();
  endtask

  // random mix in chunks, each chunk with its own idle setting
  task automatic test_random_mix();
    req_t r;
    int roll;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 30 == 0) begin
        req_idle_on = ($urandom_range(0, 3) != 0);
        rsp_idle_on = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      r.func = FUNC_TICK;
      else if (roll < 65) r.func = FUNC_SUSPEND;
      else if (roll < 85) r.func = FUNC_RESUME;
      else                r.func = FUNC_CREATE;
      r.handle = HANDLE_W'($urandom);
      r.period = PERIOD_W'($urandom);
      send_req(r);
    end
    end_burst();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
  endtask

  // receiver holds off while ticks keep coming, so the request side stalls
  task automatic test_backpressure();
    rsp_hold_len = HOLD_CYCLES;
    req_idle_on  = 1'b0;
    for (int n = 0; n < 12; n++) begin
      if (n % 4 == 3)
        send_req(make_req(FUNC_SUSPEND, $urandom_range(0, 7), $urandom));
      else
        send_req(make_req(FUNC_TICK, $urandom_range(0, 7), $urandom));
    end
    end_burst();
    req_idle_on = 1'b1;
  endtask

  // receiver side: random stall before each transfer, long hold on request
  initial begin : rsp_side
    int stall_n;
    rsp_stall <= 1'b1;
    @(posedge clk iff !rst);
    forever begin
      stall_n = pick_gap(rsp_idle_on);
      if (rsp_hold_len > 0) begin
        stall_n      = rsp_hold_len;
        rsp_hold_len = 0;
      end
      if (stall_n > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (timer_results_due.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp), 32'd0);
      end else begin
        oldest_due = timer_results_due.pop_front();
        if (rsp.new_handle !== oldest_due.new_handle)
          report_mismatch("new_handle", 32'(rsp.new_handle), 32'(oldest_due.new_handle));
        if (rsp.create_failed !== oldest_due.create_failed)
          report_mismatch("create_failed", 32'(rsp.create_failed),
                          32'(oldest_due.create_failed));
        if (rsp.fire_mask !== oldest_due.fire_mask)
          report_mismatch("fire_mask", 32'(rsp.fire_mask), 32'(oldest_due.fire_mask));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // reset, test sequence, final verdict
  initial begin
    rst            <= 1'b1;
    req_valid      <= 1'b0;
    req            <= '0;
    mismatch_count = 0;
    tick_total     = '0;
    slots_made     = 0;
    rsp_hold_len   = 0;
    req_idle_on    = 1'b1;
    rsp_idle_on    = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_period[i] = '0;
      slot_paused[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unused_slot_marks();
    test_create_fill();
    test_table_full();
    test_pause_resume();
    test_random_mix();
    test_backpressure();

    // let the last results out, then watch for stray transfers
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (TICK_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && timer_results_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
